/* hdl/set_assoc_lru_cache_tag_lookup_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative LRU tag lookup
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_TAG_LOOKUP_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAG_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication.
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/salc_pkg.sv */
// ---------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU tag lookup.
// ---------------------------------------------------------------------------
package salc_pkg;

	localparam int DEF_WAYS   = 4;
	localparam int DEF_SETS   = 256;
	localparam int DEF_ADDR_W = 32;

	localparam int BYTE_ADDR_W = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 4;

	localparam logic [3:0] LINE_LOG2_RST = 4'd5;
	localparam logic [3:0] SETS_LOG2_RST = 4'd8;
	localparam logic [2:0] WAYS_RST      = 3'd4;

	localparam logic [3:0] LINE_LOG2_MIN = 4'd2;
	localparam logic [3:0] LINE_LOG2_MAX = 4'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_SIZE_LOG2 = 2'd0,
		CFG_SET_COUNT_LOG2 = 2'd1,
		CFG_WAYS_IN_USE    = 2'd2,
		CFG_WRITE_POLICY   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		POL_FETCH    = 2'd0,
		POL_VALIDATE = 2'd1,
		POL_AROUND   = 2'd2
	} pol_t;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Outcome of one set update.
	typedef struct packed {
		logic hit;
		logic stale_miss;
		logic pass_down;
		logic row_we;
	} upd_res_t;

endpackage

/* hdl/salc_req_if.sv */
// ---------------------------------------------------------------------------
// salc_req_if
// Request channel: access kind and byte address.
// ---------------------------------------------------------------------------
interface salc_req_if;
	import salc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [BYTE_ADDR_W-1:0] byte_address;

	modport source (output valid, output req_type, output byte_address, input ready);
	modport sink   (input valid, input req_type, input byte_address, output ready);
endinterface

/* hdl/salc_rsp_if.sv */
// ---------------------------------------------------------------------------
// salc_rsp_if
// Response channel: hit, stale miss and pass-down flags.
// ---------------------------------------------------------------------------
interface salc_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic stale_miss;
	logic pass_down;

	modport source (output valid, output hit, output stale_miss, output pass_down,
		input ready);
	modport sink   (input valid, input hit, input stale_miss, input pass_down,
		output ready);
endinterface

/* hdl/set_assoc_lru_cache_tag_lookup_top.sv */
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_tag_lookup_top
// Tag array of one set-associative cache level with LRU replacement.
// ---------------------------------------------------------------------------
// Each request carries a byte address and a kind (read or write) and yields
// one response with hit, stale_miss and pass_down. Lines of a set live in one
// memory row, slot 0 least and the last slot in use most recently used. The
// accept edge reads the set row from the synchronous line memory; the
// lookup then compares the ways in use and, once the response register can
// load, writes the reordered row back on a hit or install and loads the
// response register. One request is in flight, so a request to the same
// set always sees the previous write. A new request is taken once the
// write-back is done, even while the previous response still waits in its
// output register; the lookup then holds until that register frees. After
// reset the block clears the line memory, one row per cycle, before it
// takes its first request; configuration writes are taken throughout.
// Configuration is to be written only while no request is outstanding; the
// block does not enforce it. Out-of-range register values are clamped: line
// size to 2..12, set count down to what SETS holds, ways to 1..WAYS, and a
// write policy of three acts as write around.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_tag_lookup_top #(
	parameter int WAYS   = salc_pkg::DEF_WAYS,
	parameter int SETS   = salc_pkg::DEF_SETS,
	parameter int ADDR_W = salc_pkg::DEF_ADDR_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
	salc_req_if.sink                       req,
	salc_rsp_if.source                     rsp
);
	import salc_pkg::*;

`include "set_assoc_lru_cache_tag_lookup_top_macros.svh"

	localparam int IDX_W     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WCW       = $clog2(WAYS + 1);
	localparam int ROW_W     = WAYS * ADDR_W;
	localparam int SETS_LOG2 = $clog2(SETS + 1) - 1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0] line_q;
	logic [3:0] sets_q;
	logic [2:0] ways_q;
	logic [1:0] pol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_LOG2_RST;
			sets_q <= SETS_LOG2_RST;
			ways_q <= WAYS_RST;
			pol_q  <= POL_FETCH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_SIZE_LOG2: line_q <= cfg_data[3:0];
				CFG_SET_COUNT_LOG2: sets_q <= cfg_data[3:0];
				CFG_WAYS_IN_USE:    ways_q <= cfg_data[2:0];
				CFG_WRITE_POLICY:   pol_q  <= cfg_data[1:0];
				default:            ;
			endcase
		end
	end

	// Clamp the register values into their working ranges.
	logic [3:0]     lbits;
	logic [3:0]     sbits;
	logic [WCW-1:0] ways_eff;

	always_comb begin
		priority if (line_q < LINE_LOG2_MIN) begin
			lbits = LINE_LOG2_MIN;
		end else if (line_q > LINE_LOG2_MAX) begin
			lbits = LINE_LOG2_MAX;
		end else begin
			lbits = line_q;
		end
		sbits = (32'(sets_q) > SETS_LOG2) ? 4'(SETS_LOG2) : sets_q;
		priority if (ways_q == 3'd0) begin
			ways_eff = WCW'(1);
		end else if (32'(ways_q) > WAYS) begin
			ways_eff = WCW'(WAYS);
		end else begin
			ways_eff = WCW'(ways_q);
		end
	end

	// Address split: aligned line address as tag, set index above the offset.
	logic [63:0]       addr_x;
	logic [ADDR_W-1:0] addr;
	logic [ADDR_W-1:0] aligned;
	logic [ADDR_W-1:0] set_bits;
	logic [IDX_W-1:0]  set_idx;

	assign addr_x   = 64'(req.byte_address);
	assign addr     = addr_x[ADDR_W-1:0];
	assign aligned  = addr & ~((ADDR_W'(1) << lbits) - ADDR_W'(1));
	assign set_bits = (addr >> lbits) & ((ADDR_W'(1) << sbits) - ADDR_W'(1));
	assign set_idx  = set_bits[IDX_W-1:0];

	// Request held through the lookup.
	logic [ADDR_W-3:0] tag_s1;
	logic              write_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              accept;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1   <= aligned[ADDR_W-1:2];
			write_s1 <= req.req_type;
			idx_s1   <= set_idx;
		end
	end

	// Line memory and set update.
	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] row_wr;
	upd_res_t         res;
	logic             out_load;
	logic [IDX_W-1:0] clr_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;

	salc_set_update #(
		.WAYS   (WAYS),
		.ADDR_W (ADDR_W),
		.WCW    (WCW)
	) u_update (
		.row_rd   (row_rd),
		.tag      (tag_s1),
		.is_write (write_s1),
		.policy   (pol_q),
		.ways     (ways_eff),
		.row_wr   (row_wr),
		.res      (res)
	);

	// Write back only when the response is loaded; clear rows after reset.
	always_comb begin
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_LOOK: begin
				mem_we    = out_load && res.row_we;
				mem_waddr = idx_s1;
				mem_wdata = row_wr;
			end
			default: begin
				mem_we    = 1'b0;
				mem_waddr = idx_s1;
				mem_wdata = row_wr;
			end
		endcase
	end

	salc_line_mem #(
		.DEPTH (SETS),
		.ROW_W (ROW_W),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (set_idx),
		.rdata (row_rd)
	);

	// Response register: load when free or being drained in the same cycle.
	logic out_valid_q;
	logic hit_q;
	logic stale_q;
	logic pass_q;

	assign out_load = (state_q == ST_LOOK) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q   <= res.hit;
			stale_q <= res.stale_miss;
			pass_q  <= res.pass_down;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.stale_miss = stale_q;
	assign rsp.pass_down  = pass_q;

	// Sequencer: clear sweep, wait for a request, look it up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// A taken request is looked up on the next edge.
	`SALC_ASSERT_NEXT(a_accept_to_look, accept, state_q == ST_LOOK, "accept did not start lookup")
	// A stalled lookup keeps its place until the response register frees.
	`SALC_ASSERT_NEXT(a_look_holds, (state_q == ST_LOOK) && !out_load, state_q == ST_LOOK, "lookup dropped while stalled")
	// A hit is never forwarded nor stale.
	`SALC_ASSERT_NOW(a_hit_clean, rsp.valid && rsp.hit, !rsp.pass_down && !rsp.stale_miss, "hit with miss flags")
	// No request and no response during the clearing sweep.
	`SALC_ASSERT_NOW(a_clear_quiet, state_q == ST_CLEAR, !req.ready && !rsp.valid, "activity during clear")
endmodule

/* hdl/salc_line_mem.sv */
// ---------------------------------------------------------------------------
// salc_line_mem
// One row per set holding all ways; one write and one registered read port.
// ---------------------------------------------------------------------------
module salc_line_mem #(
	parameter int DEPTH = 256,
	parameter int ROW_W = 128,
	parameter int IDX_W = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [ROW_W-1:0] wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [ROW_W-1:0] rdata
);
	logic [ROW_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hdl/salc_set_update.sv */
// ---------------------------------------------------------------------------
// salc_set_update
// Compare one set row against the tag and build the reordered row.
// ---------------------------------------------------------------------------
module salc_set_update #(
	parameter int WAYS   = 4,
	parameter int ADDR_W = 32,
	parameter int WCW    = 3
) (
	input  logic [WAYS*ADDR_W-1:0] row_rd,
	input  logic [ADDR_W-3:0]      tag,
	input  logic                   is_write,
	input  logic [1:0]             policy,
	input  logic [WCW-1:0]         ways,
	output logic [WAYS*ADDR_W-1:0] row_wr,
	output salc_pkg::upd_res_t     res
);
	import salc_pkg::*;

	localparam int SLOT_W  = ADDR_W;
	localparam int TAG_W   = ADDR_W - 2;
	localparam int PRS_BIT = ADDR_W - 1;
	localparam int INV_BIT = ADDR_W - 2;
	localparam int WIX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [SLOT_W-1:0] old_s [WAYS];
	logic [SLOT_W-1:0] up_s  [WAYS];
	logic [SLOT_W-1:0] new_s [WAYS];
	logic [WAYS-1:0]   match;
	logic [WIX_W-1:0]  elm;
	logic [WIX_W-1:0]  from;
	logic              found;
	logic              hit;
	logic              install;
	logic [SLOT_W-1:0] fill;

	for (genvar k = 0; k < WAYS; k++) begin : g_slot
		assign old_s[k] = row_rd[k*SLOT_W +: SLOT_W];
		assign match[k] = old_s[k][PRS_BIT] && (old_s[k][TAG_W-1:0] == tag)
			&& (WCW'(k) < ways);
		// Shift down toward LRU; the top slot in use takes the fill.
		if (k < WAYS - 1) begin : g_up
			assign up_s[k] = (WCW'(k + 1) < ways) ? old_s[k + 1] : fill;
		end else begin : g_top
			assign up_s[k] = fill;
		end
		assign new_s[k] = ((WIX_W'(k) >= from) && (WCW'(k) < ways)) ? up_s[k] : old_s[k];
		assign row_wr[k*SLOT_W +: SLOT_W] = new_s[k];
	end

	// Highest matching slot wins.
	always_comb begin
		found = 1'b0;
		elm   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (match[w]) begin
				found = 1'b1;
				elm   = WIX_W'(w);
			end
		end
	end

	assign hit     = found && !old_s[elm][INV_BIT];
	assign install = (is_write == REQ_READ) || (policy == POL_FETCH)
		|| (policy == POL_VALIDATE);
	assign from    = found ? elm : '0;
	assign fill    = hit ? old_s[elm]
		: {1'b1, (is_write == REQ_WRITE) && (policy == POL_VALIDATE), tag};

	assign res.hit        = hit;
	assign res.stale_miss = found && !hit;
	assign res.pass_down  = !hit && install;
	assign res.row_we     = hit || install;
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU tag lookup. A table of
// directed requests and register writes runs first, followed by random
// phases. Each phase loads new register values and then sends requests that
// mostly reuse a small pool of lines to provoke hits, evictions and stale
// copies. Each response is compared against a behavioral LRU tag store kept
// inside the bench, or against the outcome that a directed row gives.
// ---------------------------------------------------------------------------
module tb_top;
	import salc_pkg::*;

	localparam int N_WAYS      = DEF_WAYS;
	localparam int N_SETS      = DEF_SETS;
	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_REQS  = 75;
	localparam int POOL_LINES  = 10;

	// Write policy value with no enum member; the block treats it as write around.
	localparam logic [3:0] POL_RESERVED = 4'd3;

	typedef struct packed {
		logic hit;
		logic stale_miss;
		logic pass_down;
	} lookup_t;

	typedef struct packed {
		logic [BYTE_ADDR_W-1:0] line_addr;
		logic                   present;
		logic                   invalid;
	} tag_slot_t;

	typedef struct {
		bit                     is_cfg;
		cfg_reg_t               reg_idx;
		logic [CFG_DATA_W-1:0]  value;
		logic                   kind;
		logic [BYTE_ADDR_W-1:0] addr;
		bit                     typed;
		lookup_t                want;
	} stim_row_t;

	// Outcomes that can be read off directly.
	localparam lookup_t LK_HIT          = '{hit: 1'b1, stale_miss: 1'b0, pass_down: 1'b0};
	localparam lookup_t LK_MISS         = '{hit: 1'b0, stale_miss: 1'b0, pass_down: 1'b1};
	localparam lookup_t LK_STALE        = '{hit: 1'b0, stale_miss: 1'b1, pass_down: 1'b1};
	localparam lookup_t LK_STALE_AROUND = '{hit: 1'b0, stale_miss: 1'b1, pass_down: 1'b0};
	localparam lookup_t LK_BYPASS       = '{hit: 1'b0, stale_miss: 1'b0, pass_down: 1'b0};

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	salc_req_if req_ch ();
	salc_rsp_if rsp_ch ();

	set_assoc_lru_cache_tag_lookup_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #6 clk = ~clk;

	// Shadow tag store and register copies.
	tag_slot_t             tag_store [N_SETS*N_WAYS];
	logic [3:0]            line_log2_q;
	logic [3:0]            set_log2_q;
	logic [2:0]            ways_q;
	logic [1:0]            policy_q;

	// Outcomes of accepted requests, oldest first.
	lookup_t               lookup_outcomes_q [$];
	lookup_t               head_lookup;
	int                    fail_count = 0;
	int                    quiet_cycles = 0;

	// Sender burst state.
	int                    burst_left = 0;

	// Receiver stall state.
	int                    sink_cycle = 0;
	int                    sink_mode = 0;
	int                    hold_left = 0;

	stim_row_t             directed_rows [$];

	// -----------------------------------------------------------------------
	// Behavioral LRU lookup: returns the outcome and updates the shadow store.
	// Slot 0 of a set is LRU, slot ways-1 is MRU.
	// -----------------------------------------------------------------------
	function automatic lookup_t lru_lookup(logic kind, logic [BYTE_ADDR_W-1:0] addr);
		int unsigned            lbits;
		int unsigned            sbits;
		int unsigned            nways;
		int unsigned            set_base;
		int unsigned            start_slot;
		int                     way_hit;
		bit                     install;
		logic [BYTE_ADDR_W-1:0] aligned;
		tag_slot_t              fill;
		lookup_t                res;

		// Clamp the registers the same way the block does.
		lbits = 32'(line_log2_q);
		if (lbits < 32'(LINE_LOG2_MIN)) lbits = 32'(LINE_LOG2_MIN);
		if (lbits > 32'(LINE_LOG2_MAX)) lbits = 32'(LINE_LOG2_MAX);
		sbits = 32'(set_log2_q);
		while (sbits > 0 && (1 << sbits) > N_SETS) sbits--;
		nways = 32'(ways_q);
		if (nways < 1) nways = 1;
		if (nways > N_WAYS) nways = N_WAYS;

		aligned  = addr & ~((32'd1 << lbits) - 32'd1);
		set_base = ((aligned >> lbits) & ((32'd1 << sbits) - 32'd1)) * N_WAYS;

		// Search from MRU down; the full aligned address must match.
		way_hit = int'(nways) - 1;
		while (way_hit >= 0 && !(tag_store[set_base + way_hit].present &&
				tag_store[set_base + way_hit].line_addr == aligned))
			way_hit--;

		res        = LK_BYPASS;
		install    = 1'b0;
		start_slot = 0;
		fill       = '0;
		if (way_hit >= 0 && !tag_store[set_base + way_hit].invalid) begin
			res.hit    = 1'b1;
			fill       = tag_store[set_base + way_hit];
			start_slot = way_hit;
			install    = 1'b1;
		end else begin
			res.stale_miss = (way_hit >= 0);
			// Reads always install; writes install under fetch or validate only.
			if (kind != REQ_WRITE || policy_q == POL_FETCH || policy_q == POL_VALIDATE) begin
				fill.line_addr = aligned;
				fill.present   = 1'b1;
				fill.invalid   = (kind == REQ_WRITE) && (policy_q == POL_VALIDATE);
				start_slot     = res.stale_miss ? way_hit : 0;
				res.pass_down  = 1'b1;
				install        = 1'b1;
			end
		end

		// Shift the younger lines down one slot and drop the line in at MRU.
		if (install) begin
			while (start_slot + 1 < nways) begin
				tag_store[set_base + start_slot] = tag_store[set_base + start_slot + 1];
				start_slot++;
			end
			tag_store[set_base + start_slot] = fill;
		end
		return res;
	endfunction

	function automatic stim_row_t row_access(logic kind, logic [BYTE_ADDR_W-1:0] addr,
			bit typed, lookup_t want);
		stim_row_t r;
		r.is_cfg  = 1'b0;
		r.reg_idx = CFG_LINE_SIZE_LOG2;
		r.value   = '0;
		r.kind    = kind;
		r.addr    = addr;
		r.typed   = typed;
		r.want    = want;
		return r;
	endfunction

	function automatic stim_row_t row_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		stim_row_t r;
		r         = row_access(REQ_READ, '0, 1'b0, LK_BYPASS);
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.value   = value;
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Register write: drop valid, wait for every outstanding response, let
	// the block settle, then pulse the write enable for one edge.
	// -----------------------------------------------------------------------
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (lookup_outcomes_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			CFG_LINE_SIZE_LOG2: line_log2_q = value;
			CFG_SET_COUNT_LOG2: set_log2_q  = value;
			CFG_WAYS_IN_USE:    ways_q      = value[2:0];
			CFG_WRITE_POLICY:   policy_q    = value[1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Send one request. Bursts of random length are separated by random gaps;
	// within a burst valid stays high and only the payload advances.
	// -----------------------------------------------------------------------
	task automatic issue_access(logic kind, logic [BYTE_ADDR_W-1:0] addr, bit typed,
			lookup_t want);
		int      gap;
		lookup_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 3))
				0:       gap = 0;
				3:       gap = $urandom_range(8, 30);
				default: gap = $urandom_range(1, 4);
			endcase
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.byte_address <= addr;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		// Predict on acceptance; the response cannot arrive before the next edge.
		predicted = lru_lookup(kind, addr);
		lookup_outcomes_q.push_back(typed ? want : predicted);
	endtask

	// -----------------------------------------------------------------------
	// Response side: stall on a mode that is redrawn periodically (always
	// ready, random ready, or rare long holds).
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		sink_cycle <= sink_cycle + 1;
		if (sink_cycle % 256 == 0) sink_mode <= $urandom_range(0, 2);
		if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else begin
			case (sink_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
				default: begin
					if ($urandom_range(0, 15) == 0) begin
						rsp_ch.ready <= 1'b0;
						hold_left    <= $urandom_range(4, 25);
					end else begin
						rsp_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Compare every accepted response with the oldest outstanding outcome.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (lookup_outcomes_q.size() == 0) begin
				fail_count = fail_count + 1;
				if (fail_count <= 10)
					$display("%0t: response with no request outstanding: hit=%b stale=%b pass=%b",
						$realtime, rsp_ch.hit, rsp_ch.stale_miss, rsp_ch.pass_down);
			end else begin
				head_lookup = lookup_outcomes_q.pop_front();
				if (rsp_ch.hit !== head_lookup.hit ||
						rsp_ch.stale_miss !== head_lookup.stale_miss ||
						rsp_ch.pass_down !== head_lookup.pass_down) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("%0t: expected hit=%b stale=%b pass=%b, got hit=%b stale=%b pass=%b",
							$realtime, head_lookup.hit, head_lookup.stale_miss,
							head_lookup.pass_down, rsp_ch.hit, rsp_ch.stale_miss,
							rsp_ch.pass_down);
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------
	initial begin : stimulus
		logic [BYTE_ADDR_W-1:0] line_pool [POOL_LINES];
		logic [BYTE_ADDR_W-1:0] anchor;
		logic [BYTE_ADDR_W-1:0] addr;
		logic                   kind;
		stim_row_t              row;

		// Hold every input at a known value from time zero.
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_LINE_SIZE_LOG2;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_READ;
		req_ch.byte_address = '0;
		rsp_ch.ready        = 1'b0;

		foreach (tag_store[i]) tag_store[i] = '0;
		line_log2_q = LINE_LOG2_RST;
		set_log2_q  = SETS_LOG2_RST;
		ways_q      = WAYS_RST;
		policy_q    = POL_FETCH;

		// Directed table, reset configuration first: 32-byte lines, 256 sets, 4 ways.
		// An empty store never matches, so address zero misses.
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_0000, 1'b1, LK_MISS));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_001F, 1'b1, LK_HIT));
		// Top of the address space; fetch on write installs and forwards.
		directed_rows.push_back(row_access(REQ_WRITE, 32'hFFFF_FFFF, 1'b1, LK_MISS));
		directed_rows.push_back(row_access(REQ_READ,  32'hFFFF_FFE0, 1'b1, LK_HIT));
		// Fill set zero past its ways and watch the LRU line go.
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_2000, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_4000, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_6000, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_8000, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_0000, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_8000, 1'b0, LK_BYPASS));
		// Write validate: the line goes in marked invalid; lookups see it stale until a read installs it.
		directed_rows.push_back(row_config(CFG_WRITE_POLICY, 4'(POL_VALIDATE)));
		directed_rows.push_back(row_access(REQ_WRITE, 32'h1234_5678, 1'b1, LK_MISS));
		directed_rows.push_back(row_access(REQ_WRITE, 32'h1234_5678, 1'b1, LK_STALE));
		directed_rows.push_back(row_access(REQ_READ,  32'h1234_5670, 1'b1, LK_STALE));
		directed_rows.push_back(row_access(REQ_READ,  32'h1234_5678, 1'b1, LK_HIT));
		// Write around: nothing installed, nothing forwarded.
		directed_rows.push_back(row_config(CFG_WRITE_POLICY, 4'(POL_AROUND)));
		directed_rows.push_back(row_access(REQ_WRITE, 32'hA5A5_A5A5, 1'b1, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'hA5A5_A5A5, 1'b1, LK_MISS));
		directed_rows.push_back(row_access(REQ_WRITE, 32'hA5A5_A5A5, 1'b1, LK_HIT));
		// Stale copy under the reserved policy value still reports stale_miss.
		directed_rows.push_back(row_config(CFG_WRITE_POLICY, 4'(POL_VALIDATE)));
		directed_rows.push_back(row_access(REQ_WRITE, 32'h5A5A_5A5A, 1'b1, LK_MISS));
		directed_rows.push_back(row_config(CFG_WRITE_POLICY, POL_RESERVED));
		directed_rows.push_back(row_access(REQ_WRITE, 32'h5A5A_5A5A, 1'b1, LK_STALE_AROUND));
		// Register values below range: line size clamps to 4 bytes, ways to direct mapped;
		// set count above range lowers to what the store holds.
		directed_rows.push_back(row_config(CFG_LINE_SIZE_LOG2, 4'd0));
		directed_rows.push_back(row_config(CFG_SET_COUNT_LOG2, 4'd15));
		directed_rows.push_back(row_config(CFG_WAYS_IN_USE, 4'd0));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_0100, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_0500, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'h0000_0103, 1'b0, LK_BYPASS));
		// Largest line, one set, ways above range.
		directed_rows.push_back(row_config(CFG_LINE_SIZE_LOG2, 4'd15));
		directed_rows.push_back(row_config(CFG_SET_COUNT_LOG2, 4'd0));
		directed_rows.push_back(row_config(CFG_WAYS_IN_USE, 4'd7));
		directed_rows.push_back(row_access(REQ_READ,  32'hFFFF_F123, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_WRITE, 32'h0000_0FFF, 1'b0, LK_BYPASS));
		directed_rows.push_back(row_access(REQ_READ,  32'hFFFF_F000, 1'b0, LK_BYPASS));

		// Reset once; the block then clears its store before taking requests.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg)
				write_reg(row.reg_idx, row.value);
			else
				issue_access(row.kind, row.addr, row.typed, row.want);
		end

		// Random phases. The first two pin the extremes, the rest draw every
		// register from its full field so out-of-range values come up too.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == 0) begin
				write_reg(CFG_LINE_SIZE_LOG2, LINE_LOG2_MAX);
				write_reg(CFG_SET_COUNT_LOG2, SETS_LOG2_RST);
				write_reg(CFG_WAYS_IN_USE, 4'(WAYS_RST));
				write_reg(CFG_WRITE_POLICY, 4'(POL_VALIDATE));
			end else if (phase == 1) begin
				write_reg(CFG_LINE_SIZE_LOG2, LINE_LOG2_MIN);
				write_reg(CFG_SET_COUNT_LOG2, 4'd0);
				write_reg(CFG_WAYS_IN_USE, 4'd1);
				write_reg(CFG_WRITE_POLICY, 4'(POL_FETCH));
			end else begin
				write_reg(CFG_LINE_SIZE_LOG2, 4'($urandom_range(0, 15)));
				write_reg(CFG_SET_COUNT_LOG2, 4'($urandom_range(0, 15)));
				write_reg(CFG_WAYS_IN_USE, 4'($urandom_range(0, 15)));
				write_reg(CFG_WRITE_POLICY, 4'($urandom_range(0, 15)));
			end

			// Pool of lines around one anchor: high bits vary the tag so lines
			// collide in a set, a few mid bits spread them over sets.
			anchor = $urandom;
			foreach (line_pool[i])
				line_pool[i] = anchor ^ (32'($urandom_range(0, 7)) << 21) ^
					(32'($urandom_range(0, 3)) << $urandom_range(2, 12));

			for (int n = 0; n < PHASE_REQS; n++) begin
				kind = ($urandom_range(0, 9) < 4) ? REQ_WRITE : REQ_READ;
				if ($urandom_range(0, 99) < 85)
					addr = line_pool[$urandom_range(0, POOL_LINES - 1)] ^
						32'($urandom_range(0, 3));
				else
					addr = $urandom;
				issue_access(kind, addr, 1'b0, LK_BYPASS);
			end
		end

		// Drain: drop valid, wait out every response, then a few idle cycles.
		req_ch.valid <= 1'b0;
		while (lookup_outcomes_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && lookup_outcomes_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/salc_pkg.sv
hdl/salc_req_if.sv
hdl/salc_rsp_if.sv
hdl/salc_line_mem.sv
hdl/salc_set_update.sv
hdl/set_assoc_lru_cache_tag_lookup_top.sv
sim/tb_top.sv
